// ----- design/srd_pkg.sv -----
// shared types and constants for the sensor response deframer
`default_nettype none

package srd_pkg;

  localparam int SRD_WIN_LEN     = 10;
  localparam int SRD_QUEUE_DEPTH = 4;
  localparam int SRD_PRESS_SHIFT = 13;
  localparam int SRD_PRESS_STEP  = 21;

  localparam logic [7:0] SRD_START_BYTE   = 8'hAA;
  localparam logic [7:0] SRD_END_BYTE     = 8'hFF;
  localparam logic [7:0] SRD_PRESSURE_CMD = 8'hA1;

  localparam logic SRD_STATUS_OK       = 1'b0;
  localparam logic SRD_STATUS_CHK_FAIL = 1'b1;

  // one framed word handed from the front to the back
  typedef struct packed {
    logic        status;
    logic [7:0]  cmd;
    logic [7:0]  addr;
    logic        neg;
    logic [23:0] mag;
  } srd_frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } srd_queue_status_t;

  typedef struct packed {
    logic push;
  } srd_front_status_t;

endpackage

`default_nettype wire

// ----- design/sensor_response_deframer.sv -----
// top level of the sensor response deframer
//
// Input channel: one received byte per word on rx_byte, taken when push is
// high and full is low. Result channel: one word per detected frame, shown
// while empty is low and taken when pop is high. A frame is ten bytes from
// 0xAA to 0xFF; a good checksum gives status 0 with command, address and
// signed reading, a bad one gives status 1 with the held pressure.
// Pressure is refreshed by good frames with command 0xA1 using cfg_data,
// the zero-point reading, written with cfg_we. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Throughput: one byte per cycle while full is low. The byte window, frame
// compare and six-byte sum are evaluated in the cycle a byte is taken.
// A frame is written into the queue by the edge that takes its end byte;
// the output register loads the queue head while empty or being popped.
// When pop stays low, frames collect in the queue; full rises once the
// queue holds QUEUE_DEPTH frames and stays high until one is popped.
// Reset clears the window, the queue, the output valid flag, the held
// pressure and the zero-point register.
`default_nettype none

module sensor_response_deframer
  import srd_pkg::*;
#(
  parameter int QUEUE_DEPTH = SRD_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               cfg_we,
  input  wire logic signed [24:0] cfg_data,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    frame_status,
  output logic [7:0]              command_code,
  output logic [7:0]              device_address,
  output logic                    reading_negative,
  output logic signed [24:0]      reading,
  output logic signed [17:0]      pressure,
  output logic                    pressure_fresh
);

  logic signed [24:0] zero_offset;
  logic               accept;
  srd_frame_t         front_frame;
  srd_front_status_t  front_status;
  srd_frame_t         q_head;
  srd_queue_status_t  q_status;
  logic               q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
    end else if (cfg_we) begin
      zero_offset <= cfg_data;
    end
  end

  assign full   = q_status.full;
  assign accept = push && !full;

  srd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .frame        (front_frame),
    .front_status (front_status)
  );

  srd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_status.push),
    .wr_data  (front_frame),
    .rd_en    (q_take),
    .rd_data  (q_head),
    .q_status (q_status)
  );

  srd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (q_head),
    .head_valid       (!q_status.empty),
    .zero_offset      (zero_offset),
    .pop              (pop),
    .head_take        (q_take),
    .empty            (empty),
    .frame_status     (frame_status),
    .command_code     (command_code),
    .device_address   (device_address),
    .reading_negative (reading_negative),
    .reading          (reading),
    .pressure         (pressure),
    .pressure_fresh   (pressure_fresh)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("output or queue not cleared by reset");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    front_status.push |-> !q_status.full)
    else $error("frame written into a full queue");

  a_take_has_word: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !q_status.empty)
    else $error("frame taken from an empty queue");

  a_frame_ends_word: assert property (@(posedge clk) disable iff (rst)
    front_status.push |-> (accept && rx_byte == SRD_END_BYTE))
    else $error("frame found without an accepted end byte");

endmodule

`default_nettype wire

// ----- design/srd_front.sv -----
// front end: byte window, frame detection and checksum
`default_nettype none

module srd_front
  import srd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        rx_byte,
  output srd_frame_t             frame,
  output srd_front_status_t      front_status
);

  logic [7:0]  window      [SRD_WIN_LEN];
  logic [7:0]  window_next [SRD_WIN_LEN];
  logic [15:0] sum;
  logic [15:0] chk;
  logic        found;
  logic        chk_ok;
  logic [7:0]  sign_byte;

  always_comb begin
    for (int i = 0; i < SRD_WIN_LEN - 1; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[SRD_WIN_LEN - 1] = rx_byte;
  end

  assign found = (window_next[0] == SRD_START_BYTE) &&
                 (window_next[SRD_WIN_LEN - 1] == SRD_END_BYTE);

  assign sum = 16'(window_next[1]) + 16'(window_next[2]) + 16'(window_next[3]) +
               16'(window_next[4]) + 16'(window_next[5]) + 16'(window_next[6]);
  assign chk    = {window_next[7], window_next[8]};
  assign chk_ok = (sum == chk);
  assign sign_byte = window_next[3];

  always_comb begin
    frame = '0;
    if (chk_ok) begin
      frame.status = SRD_STATUS_OK;
      frame.cmd    = window_next[1];
      frame.addr   = window_next[2];
      frame.neg    = (sign_byte == 8'd1);
      frame.mag    = {window_next[4], window_next[5], window_next[6]};
    end else begin
      frame.status = SRD_STATUS_CHK_FAIL;
    end
  end

  assign front_status.push = accept && found;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SRD_WIN_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      // a good frame is consumed, a bad one keeps sliding
      if (found && chk_ok) begin
        for (int i = 0; i < SRD_WIN_LEN; i++) begin
          window[i] <= '0;
        end
      end else begin
        for (int i = 0; i < SRD_WIN_LEN; i++) begin
          window[i] <= window_next[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/srd_queue.sv -----
// short frame queue between front and back
`default_nettype none

module srd_queue
  import srd_pkg::*;
#(
  parameter int DEPTH = SRD_QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  srd_frame_t        wr_data,
  input  wire logic         rd_en,
  output srd_frame_t        rd_data,
  output srd_queue_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srd_frame_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign rd_data        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/srd_back.sv -----
// back end: reading, pressure and output register
`default_nettype none

module srd_back
  import srd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  srd_frame_t              head,
  input  wire logic               head_valid,
  input  wire logic signed [24:0] zero_offset,
  input  wire logic               pop,
  output logic                    head_take,
  output logic                    empty,
  output logic                    frame_status,
  output logic [7:0]              command_code,
  output logic [7:0]              device_address,
  output logic                    reading_negative,
  output logic signed [24:0]      reading,
  output logic signed [17:0]      pressure,
  output logic                    pressure_fresh
);

  localparam int Q_W = 25 - SRD_PRESS_SHIFT;
  localparam logic signed [17:0] STEP = 18'(SRD_PRESS_STEP);

  logic                  out_valid;
  logic signed [17:0]    last_pressure;
  logic signed [24:0]    rd_val;
  logic signed [Q_W-1:0] rd_sh;
  logic signed [Q_W-1:0] zr_sh;
  logic signed [Q_W:0]   diff;
  logic signed [17:0]    diff_ext;
  logic signed [17:0]    press_new;
  logic                  fresh;

  assign rd_val = head.neg ? -$signed({1'b0, head.mag}) : $signed({1'b0, head.mag});
  assign rd_sh  = Q_W'(rd_val >>> SRD_PRESS_SHIFT);
  assign zr_sh  = Q_W'(zero_offset >>> SRD_PRESS_SHIFT);
  assign diff   = $signed({zr_sh[Q_W-1], zr_sh[Q_W-1:0]}) -
                  $signed({rd_sh[Q_W-1], rd_sh[Q_W-1:0]});
  assign diff_ext  = 18'(diff);
  assign press_new = diff_ext * STEP;
  assign fresh = (head.status == SRD_STATUS_OK) && (head.cmd == SRD_PRESSURE_CMD);

  assign head_take = head_valid && (!out_valid || pop);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_pressure <= '0;
    end else begin
      if (head_take) begin
        out_valid <= 1'b1;
        if (fresh) begin
          last_pressure <= press_new;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      frame_status     <= head.status;
      command_code     <= head.cmd;
      device_address   <= head.addr;
      reading_negative <= head.neg;
      reading          <= rd_val;
      pressure         <= fresh ? press_new : last_pressure;
      pressure_fresh   <= fresh;
    end
  end

endmodule

`default_nettype wire
